// File: rtl/core/prsf_pkg.sv
// Shared types and constants of the polygon row span fill block.
package prsf_pkg;

  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 11;
  localparam int SPAN_W     = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int EPOCH_W    = 4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLR_INIT,
    ST_IDLE,
    ST_CLR_START,
    ST_MARK0,
    ST_DIV,
    ST_WALK,
    ST_QRD,
    ST_QEVAL,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic epoch_adv;
    logic epoch_init;
    logic mark_first;
    logic walk_step;
    logic query_rd;
    logic take_query;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flat;
    logic div_done;
    logic walk_last;
    logic clr_last;
    logic epoch_full;
    logic out_full;
  } dp_status_t;

endpackage

// File: rtl/core/prsf_in_if.sv
// Request channel carrying one polygon command or row query.
interface prsf_in_if #(
  parameter int COORD_BITS = 13
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  modport source (output valid, mode, point_x, point_y, input ready);
  modport sink   (input valid, mode, point_x, point_y, output ready);
endinterface

// File: rtl/core/prsf_out_if.sv
// Response channel carrying acknowledgements and row span answers.
interface prsf_out_if import prsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              row_filled;
  logic [SPAN_W-1:0] span_start;
  logic [SPAN_W-1:0] span_end;
  logic              is_query_answer;

  modport source (output valid, row_filled, span_start, span_end, is_query_answer,
                  input ready);
  modport sink   (input valid, row_filled, span_start, span_end, is_query_answer,
                  output ready);
endinterface

// File: rtl/core/prsf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module prsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/prsf_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
module prsf_div #(
  parameter int WIDTH = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o,
  output logic             done_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held for more than one cycle");

endmodule

// File: rtl/core/prsf_datapath.sv
// Datapath: vertex registers, edge walker, row store pipeline and response register.
module prsf_datapath import prsf_pkg::*; #(
  parameter int MAX_ROWS   = 1024,
  parameter int COORD_BITS = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_cmd_t                    cmd_i,
  output dp_status_t                   status_o,
  input  mode_e                        in_mode_i,
  input  logic signed [COORD_BITS-1:0] in_point_x_i,
  input  logic signed [COORD_BITS-1:0] in_point_y_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         out_row_filled_o,
  output logic [SPAN_W-1:0]            out_span_start_o,
  output logic [SPAN_W-1:0]            out_span_end_o,
  output logic                         out_is_query_answer_o
);

  localparam int C    = COORD_BITS;
  localparam int AW   = $clog2(MAX_ROWS);
  localparam int RB   = $clog2(MAX_ROWS + 1);
  localparam int RUW  = (RB > HEIGHT_W) ? RB : HEIGHT_W;
  localparam int CMPW = ((C > RUW) ? C : RUW) + 1;
  localparam int SW   = ((C > WIDTH_W) ? C : WIDTH_W) + 2;
  localparam int DW   = EPOCH_W + 2 * C;

  localparam logic signed [C-1:0]  ONE_C    = C'(1);
  localparam logic signed [SW-1:0] ONE_S    = SW'(1);
  localparam logic [CMPW-1:0]      ROWS_CAP = CMPW'(MAX_ROWS);
  localparam logic [AW-1:0]        LAST_ROW = AW'(MAX_ROWS - 1);

  // Configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertices and the captured edge
  logic signed [C-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [C-1:0] tgt_x, tgt_y;
  logic signed [C:0]   dx_full, dy_full, dx_abs, dy_abs;
  logic signed [C-1:0] e_x1_q, e_y1_q, e_y2_q;
  logic [C-1:0]        e_dxmag_q, e_den_q;
  logic                e_dxneg_q, e_up_q, e_flat_q, is_query_q;

  assign tgt_x   = (in_mode_i == MODE_ADD) ? in_point_x_i : first_x_q;
  assign tgt_y   = (in_mode_i == MODE_ADD) ? in_point_y_i : first_y_q;
  assign dx_full = {tgt_x[C-1], tgt_x} - {prev_x_q[C-1], prev_x_q};
  assign dy_full = {tgt_y[C-1], tgt_y} - {prev_y_q[C-1], prev_y_q};
  assign dx_abs  = dx_full[C] ? -dx_full : dx_full;
  assign dy_abs  = dy_full[C] ? -dy_full : dy_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (cmd_i.capture) begin
      case (in_mode_i)
        MODE_START: begin
          first_x_q <= in_point_x_i;
          first_y_q <= in_point_y_i;
          prev_x_q  <= in_point_x_i;
          prev_y_q  <= in_point_y_i;
        end
        MODE_ADD, MODE_CLOSE: begin
          prev_x_q <= tgt_x;
          prev_y_q <= tgt_y;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_query_q <= (in_mode_i == MODE_QUERY);
      if (in_mode_i == MODE_QUERY) begin
        e_y1_q <= in_point_y_i;
      end else begin
        e_x1_q    <= prev_x_q;
        e_y1_q    <= prev_y_q;
        e_y2_q    <= tgt_y;
        e_dxneg_q <= dx_full[C];
        e_dxmag_q <= dx_abs[C-1:0];
        e_den_q   <= dy_abs[C-1:0];
        e_up_q    <= !dy_full[C];
        e_flat_q  <= (dy_full == '0);
      end
    end
  end

  // Per-edge slope division: |dx| / |dy| as unsigned quotient and remainder
  logic [C-1:0] div_quo, div_rem;
  logic         div_done;

  prsf_div #(
    .WIDTH (C)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.mark_first && !e_flat_q),
    .dividend_i  (e_dxmag_q),
    .divisor_i   (e_den_q),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  // Row walker. Position is tracked as q*D + r with 0 <= r < D, so each row
  // needs one add and compare; truncation toward zero is a final fix-up.
  logic signed [C:0]   q_q, dq_q, q_n, dq_n, qa_s, round_ext, carry_ext, xt;
  logic [C-1:0]        r_q, dr_q, r_n, dr_n;
  logic signed [C-1:0] y_q, y_n;
  logic [C:0]          rsum, rdiff;
  logic                carry, round;

  assign round     = (div_rem != '0);
  assign qa_s      = $signed({1'b0, div_quo});
  assign round_ext = $signed({{C{1'b0}}, round});
  assign dq_n      = e_dxneg_q ? -(qa_s + round_ext) : qa_s;
  assign dr_n      = !e_dxneg_q ? div_rem : (round ? (e_den_q - div_rem) : '0);

  assign rsum      = {1'b0, r_q} + {1'b0, dr_q};
  assign rdiff     = rsum - {1'b0, e_den_q};
  assign carry     = rsum >= {1'b0, e_den_q};
  assign r_n       = carry ? rdiff[C-1:0] : rsum[C-1:0];
  assign carry_ext = $signed({{C{1'b0}}, carry});
  assign q_n       = q_q + dq_q + carry_ext;
  assign xt        = q_n + $signed({{C{1'b0}}, (q_n[C] && (r_n != '0))});
  assign y_n       = e_up_q ? (y_q + ONE_C) : (y_q - ONE_C);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_first) begin
      q_q <= {e_x1_q[C-1], e_x1_q};
      r_q <= '0;
      y_q <= e_y1_q;
    end else if (cmd_i.walk_step) begin
      q_q <= q_n;
      r_q <= r_n;
      y_q <= y_n;
    end
    if (div_done) begin
      dq_q <= dq_n;
      dr_q <= dr_n;
    end
  end

  // Row store request, first stage: range check and read
  logic                req_en, req_wr, in_range;
  logic signed [C-1:0] req_x, req_y;
  logic [CMPW-1:0]     y_ext, height_ext, rows_used;

  assign req_wr     = cmd_i.mark_first || cmd_i.walk_step;
  assign req_en     = req_wr || cmd_i.query_rd;
  assign req_x      = cmd_i.walk_step ? xt[C-1:0] : e_x1_q;
  assign req_y      = cmd_i.walk_step ? y_n : e_y1_q;
  assign y_ext      = {{(CMPW-C){req_y[C-1]}}, req_y};
  assign height_ext = CMPW'(height_q);
  assign rows_used  = (height_ext > ROWS_CAP) ? ROWS_CAP : height_ext;
  assign in_range   = !req_y[C-1] && (y_ext < rows_used);

  logic                s1_in_q, s1_wr_q;
  logic [AW-1:0]       s1_addr_q;
  logic signed [C-1:0] s1_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_in_q <= 1'b0;
      s1_wr_q <= 1'b0;
    end else begin
      s1_in_q <= req_en && in_range;
      s1_wr_q <= req_wr && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= y_ext[AW-1:0];
    s1_x_q    <= req_x;
  end

  // Clearing sweep and polygon epoch. An entry counts as touched only when
  // its tag equals the current epoch; tag zero is never a live epoch.
  logic [AW-1:0]      clr_cnt_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic               clr_last;

  assign clr_last = (clr_cnt_q == LAST_ROW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      epoch_q   <= EPOCH_W'(1);
    end else begin
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_last ? '0 : (clr_cnt_q + AW'(1));
      end
      if (cmd_i.epoch_init) begin
        epoch_q <= EPOCH_W'(1);
      end else if (cmd_i.epoch_adv) begin
        epoch_q <= epoch_q + EPOCH_W'(1);
      end
    end
  end

  // Second stage: merge with the stored entry and write back
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  prsf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (y_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // The write of the previous cycle is not yet visible in the read data.
  logic                fwd_v_q;
  logic [AW-1:0]       fwd_addr_q;
  logic [DW-1:0]       fwd_data_q, ent;
  logic [EPOCH_W-1:0]  ent_tag;
  logic signed [C-1:0] ent_min, ent_max, new_min, new_max;
  logic                touched;

  assign ent     = (fwd_v_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : ram_rdata;
  assign ent_tag = ent[DW-1 -: EPOCH_W];
  assign ent_min = ent[2*C-1:C];
  assign ent_max = ent[C-1:0];
  assign touched = s1_in_q && (ent_tag == epoch_q);
  assign new_min = (!touched || (s1_x_q < ent_min)) ? s1_x_q : ent_min;
  assign new_max = (!touched || (s1_x_q > ent_max)) ? s1_x_q : ent_max;

  assign ram_we    = s1_wr_q || cmd_i.clr_en;
  assign ram_waddr = cmd_i.clr_en ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = cmd_i.clr_en ? '0 : {epoch_q, new_min, new_max};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= ram_waddr;
    fwd_data_q <= ram_wdata;
  end

  // Span clipping for queries
  logic signed [SW-1:0] min_ext, max_ext, width_ext, lim, s_cl, e_cl;
  logic                 filled;

  assign min_ext   = {{(SW-C){ent_min[C-1]}}, ent_min};
  assign max_ext   = {{(SW-C){ent_max[C-1]}}, ent_max};
  assign width_ext = $signed({{(SW-WIDTH_W){1'b0}}, width_q});
  assign lim       = width_ext - ONE_S;
  assign s_cl      = min_ext[SW-1] ? '0 : min_ext;
  assign e_cl      = (max_ext > lim) ? lim : max_ext;
  assign filled    = touched && (s_cl <= e_cl);

  logic              res_filled_q;
  logic [SPAN_W-1:0] res_start_q, res_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_query) begin
      res_filled_q <= filled;
      res_start_q  <= filled ? s_cl[SPAN_W-1:0] : '0;
      res_end_q    <= filled ? e_cl[SPAN_W-1:0] : '0;
    end
  end

  // Response register
  logic              out_valid_q, out_filled_q, out_query_q;
  logic [SPAN_W-1:0] out_start_q, out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_filled_q <= is_query_q && res_filled_q;
      out_start_q  <= is_query_q ? res_start_q : '0;
      out_end_q    <= is_query_q ? res_end_q : '0;
      out_query_q  <= is_query_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_row_filled_o      = out_filled_q;
  assign out_span_start_o      = out_start_q;
  assign out_span_end_o        = out_end_q;
  assign out_is_query_answer_o = out_query_q;

  assign status_o.flat       = e_flat_q;
  assign status_o.div_done   = div_done;
  assign status_o.walk_last  = (y_n == e_y2_q);
  assign status_o.clr_last   = clr_last;
  assign status_o.epoch_full = &epoch_q;
  assign status_o.out_full   = out_valid_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_wr_q && cmd_i.clr_en))
    else $error("row update collides with clearing sweep");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch reached the untouched tag");

endmodule

// File: rtl/core/prsf_ctrl.sv
// Controller state machine sequencing clears, edge walks, queries and responses.
module prsf_ctrl import prsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  mode_e      in_mode_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR_INIT: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_mode_i)
            MODE_START: state_d = status_i.epoch_full ? ST_CLR_START : ST_RESP;
            MODE_ADD:   state_d = ST_MARK0;
            MODE_CLOSE: state_d = ST_MARK0;
            MODE_QUERY: state_d = ST_QRD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLR_START: begin
        if (status_i.clr_last) state_d = ST_RESP;
      end
      ST_MARK0: state_d = status_i.flat ? ST_RESP : ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (status_i.walk_last) state_d = ST_RESP;
      end
      ST_QRD:   state_d = ST_QEVAL;
      ST_QEVAL: state_d = ST_RESP;
      ST_RESP: begin
        if (!status_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_CLR_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLR_INIT, ST_CLR_START: begin
        cmd_o.clr_en     = 1'b1;
        cmd_o.epoch_init = status_i.clr_last;
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.capture   = in_valid_i;
        cmd_o.epoch_adv = in_valid_i && (in_mode_i == MODE_START) && !status_i.epoch_full;
      end
      ST_MARK0: cmd_o.mark_first = 1'b1;
      ST_WALK:  cmd_o.walk_step  = !status_i.walk_last;
      ST_QRD:   cmd_o.query_rd   = 1'b1;
      ST_QEVAL: cmd_o.take_query = 1'b1;
      ST_RESP:  cmd_o.load_out   = !status_i.out_full;
      default: ;
    endcase
  end

  a_walk_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && $past(state_q) != ST_WALK) |-> $past(status_i.div_done))
    else $error("edge walk began without a slope result");

endmodule

// File: rtl/core/polygon_row_span_fill.sv
// Each edge walks one row per cycle after a slope division.
// Items are handled one at a time; a response register lets the next request in early.
// Every fifteenth polygon start sweeps the row store.
// After reset the row store is cleared before a request is accepted.
module polygon_row_span_fill import prsf_pkg::*; #(
  parameter int MAX_ROWS   = 1024,
  parameter int COORD_BITS = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  prsf_in_if.sink               in_if,
  prsf_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_mode_i  (mode_e'(in_if.mode)),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prsf_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .in_mode_i             (mode_e'(in_if.mode)),
    .in_point_x_i          (in_if.point_x),
    .in_point_y_i          (in_if.point_y),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .out_ready_i           (out_if.ready),
    .out_valid_o           (out_if.valid),
    .out_row_filled_o      (out_if.row_filled),
    .out_span_start_o      (out_if.span_start),
    .out_span_end_o        (out_if.span_end),
    .out_is_query_answer_o (out_if.is_query_answer)
  );

endmodule
